[hdl/four_level_page_table_mapper_top_macros.svh]
// Assertion macros for the four-level page table mapper checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_TOP_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_TOP_MACROS_SVH

// same-cycle implication, reset masked
`define FLPTM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mapper check failed");

// next-cycle implication, reset masked
`define FLPTM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mapper check failed");

`endif

[hdl/flptm_pkg.sv]
// Shared constants for the four-level page table mapper.
// No dependencies.
`default_nettype none
package flptm_pkg;
	localparam int DEF_TABLE_FRAMES = 16;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W = 9;

	localparam logic [1:0] REQ_MAP       = 2'd0;
	localparam logic [1:0] REQ_UNMAP     = 2'd1;
	localparam logic [1:0] REQ_TRANSLATE = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOT_MAP  = 3'd1;
	localparam logic [2:0] ST_NO_FRAME = 3'd2;
	localparam logic [2:0] ST_ZERO     = 3'd3;
	localparam logic [2:0] ST_HUGE     = 3'd4;
endpackage
`default_nettype wire

[hdl/four_level_page_table_mapper_top.sv]
// Four-level page table mapper: table store, walk sequencer and allocator.
// Depends on flptm_pkg.
//
// After reset the block clears the root table with busy high.
// A request is taken when start is high and busy low; one result follows, shown
// for a single cycle with done, and the receiver cannot stall it. Each page reads
// its table levels one at a time through the single store read port; allocating
// a table adds a clear and a split adds a fill of the new table, one entry
// written per cycle.
`default_nettype none
module four_level_page_table_mapper_top #(
	parameter int TABLE_FRAMES = flptm_pkg::DEF_TABLE_FRAMES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [47:0] virt_address,
	input  wire logic [51:0] phys_address,
	input  wire logic [11:0] entry_flags,
	input  wire logic [9:0]  page_count,
	input  wire logic        table_base_we,
	input  wire logic [51:0] table_base,
	output logic             done,
	output logic [51:0]      phys_result,
	output logic [2:0]       status
);
	localparam int IW  = flptm_pkg::IDX_W;
	localparam int FBW = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
	localparam int NFW = $clog2(TABLE_FRAMES + 1);
	localparam int AW  = FBW + IW;
	localparam int DEPTH = TABLE_FRAMES * flptm_pkg::ENTRIES_PER_TABLE;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_PAGE = 4'd2;
	localparam logic [3:0] S_RD   = 4'd3;
	localparam logic [3:0] S_EV   = 4'd4;
	localparam logic [3:0] S_FILL = 4'd5;
	localparam logic [3:0] S_WRL  = 4'd6;
	localparam logic [3:0] S_NEXT = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0]     state_q;
	logic           boot_q;
	logic [1:0]     lv_q;
	logic [FBW-1:0] frame_q;
	logic [IW-1:0]  idx_q;
	logic [NFW-1:0] next_free_q;
	logic [39:0]    base_q;
	logic [1:0]     req_q;
	logic [47:0]    virt_q;
	logic [51:0]    phys_q;
	logic [11:0]    flags_q;
	logic [9:0]     count_q;
	logic           skipped_q;
	logic [2:0]     status_q;
	logic [51:0]    result_q;
	logic [63:0]    orig_q;
	logic           done_q;
	logic [51:0]    res_phys_q;
	logic [2:0]     res_status_q;

	logic [63:0]    mem [DEPTH];
	logic [63:0]    rdata_q;
	logic           mem_we;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  raddr;
	logic [63:0]    wdata;

	logic [IW-1:0]  lvl_idx;
	logic [IW-1:0]  leaf_idx;
	logic [11:0]    fl;
	logic [11:0]    pfl;
	logic           e_pres;
	logic           e_huge;
	logic [39:0]    dec_diff;
	logic           dec_ok;
	logic [FBW-1:0] dec_frame;
	logic           can_alloc;
	logic [39:0]    new_fa;
	logic           agree;
	logic           huge_match;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign phys_result = res_phys_q;
	assign status = res_status_q;

	always_comb begin
		unique case (lv_q)
			2'd3: lvl_idx = virt_q[47:39];
			2'd2: lvl_idx = virt_q[38:30];
			2'd1: lvl_idx = virt_q[29:21];
			default: lvl_idx = virt_q[20:12];
		endcase
	end

	assign leaf_idx   = virt_q[20:12];
	assign fl         = {flags_q[11:1], 1'b1};
	assign pfl        = {fl[11:8], 1'b0, fl[6:0]};
	assign e_pres     = rdata_q[0];
	assign e_huge     = rdata_q[7];
	assign dec_diff   = rdata_q[51:12] - base_q;
	assign dec_ok     = (dec_diff < 40'(TABLE_FRAMES));
	assign dec_frame  = dec_diff[FBW-1:0];
	assign can_alloc  = (next_free_q < NFW'(TABLE_FRAMES));
	assign new_fa     = base_q + 40'(next_free_q);
	assign agree      = (phys_q[20:0] == virt_q[20:0]);
	assign huge_match = agree && (rdata_q[51:12] == {phys_q[51:21], 9'd0});
	assign raddr      = {frame_q, lvl_idx};

	always_comb begin
		mem_we = 1'b0;
		waddr  = raddr;
		wdata  = '0;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				waddr  = {frame_q, idx_q};
			end
			S_FILL: begin
				mem_we = 1'b1;
				waddr  = {frame_q, idx_q};
				wdata  = {orig_q[63:52], orig_q[51:12] + 40'(idx_q), orig_q[11:0]};
			end
			S_WRL: begin
				mem_we = 1'b1;
				waddr  = {frame_q, leaf_idx};
				wdata  = {12'd0, phys_q[51:12], fl};
			end
			S_EV: begin
				if (req_q == flptm_pkg::REQ_MAP && !e_pres) begin
					if (lv_q == 2'd1 && agree) begin
						mem_we = 1'b1;
						wdata  = {12'd0, phys_q[51:21], 9'd0, fl[11:8], 1'b1, fl[6:0]};
					end else if (can_alloc) begin
						mem_we = 1'b1;
						wdata  = {12'd0, new_fa, pfl};
					end
				end else if (req_q == flptm_pkg::REQ_UNMAP && lv_q == 2'd0) begin
					mem_we = 1'b1;
					wdata  = {rdata_q[63:1], 1'b0};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q   <= req_type;
			virt_q  <= virt_address;
			phys_q  <= phys_address;
			flags_q <= entry_flags;
			count_q <= page_count;
		end else if (state_q == S_NEXT) begin
			count_q <= count_q - 10'd1;
			virt_q  <= virt_q + 48'h1000;
			phys_q  <= phys_q + 52'h1000;
		end
		if (state_q == S_EV) begin
			orig_q <= {rdata_q[63:8], 1'b0, rdata_q[6:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			boot_q       <= 1'b1;
			lv_q         <= 2'd3;
			frame_q      <= '0;
			idx_q        <= '0;
			next_free_q  <= NFW'(1);
			base_q       <= '0;
			skipped_q    <= 1'b0;
			status_q     <= flptm_pkg::ST_OK;
			result_q     <= '0;
			done_q       <= 1'b0;
			res_phys_q   <= '0;
			res_status_q <= flptm_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			if (table_base_we) begin
				base_q <= table_base[51:12];
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						skipped_q <= 1'b0;
						status_q  <= flptm_pkg::ST_OK;
						result_q  <= '0;
						if (req_type == flptm_pkg::REQ_TRANSLATE ||
							((req_type == flptm_pkg::REQ_MAP ||
							  req_type == flptm_pkg::REQ_UNMAP) && page_count != 10'd0)) begin
							state_q <= S_PAGE;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_CLR: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == '1) begin
						state_q <= boot_q ? S_IDLE : S_RD;
						boot_q  <= 1'b0;
					end
				end
				S_PAGE: begin
					lv_q    <= 2'd3;
					frame_q <= '0;
					if (req_q == flptm_pkg::REQ_MAP && (phys_q == '0 || virt_q == '0)) begin
						skipped_q <= 1'b1;
						state_q   <= S_NEXT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					case (req_q)
						flptm_pkg::REQ_MAP: begin
							if (lv_q != 2'd1) begin
								if (!e_pres) begin
									if (!can_alloc) begin
										status_q <= flptm_pkg::ST_NO_FRAME;
										state_q  <= S_FIN;
									end else begin
										frame_q     <= next_free_q[FBW-1:0];
										next_free_q <= next_free_q + NFW'(1);
										lv_q        <= lv_q - 2'd1;
										idx_q       <= '0;
										state_q     <= S_CLR;
									end
								end else if (!dec_ok) begin
									status_q <= flptm_pkg::ST_NOT_MAP;
									state_q  <= S_FIN;
								end else begin
									frame_q <= dec_frame;
									lv_q    <= lv_q - 2'd1;
									state_q <= S_RD;
								end
							end else if (e_pres) begin
								if (e_huge) begin
									if (huge_match) begin
										state_q <= S_NEXT;
									end else begin
										status_q <= flptm_pkg::ST_HUGE;
										state_q  <= S_FIN;
									end
								end else if (!dec_ok) begin
									status_q <= flptm_pkg::ST_NOT_MAP;
									state_q  <= S_FIN;
								end else begin
									frame_q <= dec_frame;
									state_q <= S_WRL;
								end
							end else if (agree) begin
								state_q <= S_NEXT;
							end else if (!can_alloc) begin
								status_q <= flptm_pkg::ST_NO_FRAME;
								state_q  <= S_FIN;
							end else begin
								frame_q     <= next_free_q[FBW-1:0];
								next_free_q <= next_free_q + NFW'(1);
								idx_q       <= '0;
								state_q     <= S_FILL;
							end
						end
						flptm_pkg::REQ_UNMAP: begin
							if (lv_q == 2'd0) begin
								state_q <= S_NEXT;
							end else if (!e_pres || !dec_ok || (lv_q == 2'd1 && e_huge)) begin
								state_q <= S_NEXT;
							end else begin
								frame_q <= dec_frame;
								lv_q    <= lv_q - 2'd1;
								state_q <= S_RD;
							end
						end
						default: begin
							state_q <= S_FIN;
							if (lv_q == 2'd0) begin
								if (e_pres) begin
									result_q <= {rdata_q[51:12], virt_q[11:0]};
								end else begin
									status_q <= flptm_pkg::ST_NOT_MAP;
								end
							end else if (!e_pres) begin
								status_q <= flptm_pkg::ST_NOT_MAP;
							end else if (lv_q == 2'd1 && e_huge) begin
								result_q <= {rdata_q[51:21], virt_q[20:0]};
							end else if (!dec_ok) begin
								status_q <= flptm_pkg::ST_NOT_MAP;
							end else begin
								frame_q <= dec_frame;
								lv_q    <= lv_q - 2'd1;
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_FILL: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == '1) begin
						state_q <= S_WRL;
					end
				end
				S_WRL: begin
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					state_q <= (count_q == 10'd1) ? S_FIN : S_PAGE;
				end
				S_FIN: begin
					done_q     <= 1'b1;
					res_phys_q <= result_q;
					if (req_q == flptm_pkg::REQ_MAP && status_q == flptm_pkg::ST_OK &&
						skipped_q) begin
						res_status_q <= flptm_pkg::ST_ZERO;
					end else begin
						res_status_q <= status_q;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/flptm_checker.sv]
// Port-level checker for the four-level page table mapper, bound to the top.
// Depends on flptm_pkg and four_level_page_table_mapper_top_macros.svh.
`default_nettype none
`include "four_level_page_table_mapper_top_macros.svh"
module flptm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [51:0] phys_result,
	input wire logic [2:0]  status
);
	`FLPTM_ASSERT_SAME(a_done_idle, done, !busy)
	`FLPTM_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`FLPTM_ASSERT_SAME(a_status_range, done, status <= flptm_pkg::ST_HUGE)
	`FLPTM_ASSERT_SAME(a_fail_zero, done && status != flptm_pkg::ST_OK, phys_result == 52'd0)
endmodule

bind four_level_page_table_mapper_top flptm_checker u_flptm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.phys_result(phys_result),
	.status(status)
);
`default_nettype wire
